// File: rtl/core/gomv_pkg.sv
// Package for the gradient orientation majority vote block.
// Holds widths, register codes, pipeline structs and the angle-to-label function.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package gomv_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = ADDR_W + 1;

  // Field widths
  localparam int ANGLE_W = 13;
  localparam int MAG_W   = 15;
  localparam int LABEL_W = 4;
  localparam int NUM_LABELS = 16;
  localparam int CFG_W   = 11;
  localparam int ROW_W   = CFG_W + 1;
  localparam int LINE_W  = 2 * LABEL_W + MAG_W;

  // Window
  localparam int WIN_SIDE = 3;
  localparam int WIN_TAPS = WIN_SIDE * WIN_SIDE;
  localparam int VOTE_MIN = WIN_TAPS / 2 + 1;
  localparam int CNT_W    = $clog2(WIN_TAPS + 1);

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_e;

  localparam logic [MAG_W-1:0] THRESHOLD_RESET = 15'd7680;
  localparam logic [CFG_W-1:0] WIDTH_RESET     = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET    = 11'd480;

  // floor(a / 180) as (a * RECIP_MULT) >> RECIP_SHIFT, exact for a < 2^16
  localparam int RECIP_SHIFT = 21;
  localparam logic [13:0] RECIP_MULT = 14'd11651;
  localparam logic [13:0] HALF_STEP  = 14'd90;

  // Item handed from the front end to the window stage
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LABEL_W-1:0] lab;
    logic [MAG_W-1:0]   mag;
    logic               res;
    logic               deferred;
    logic               use_top;
    logic               use_bot;
    logic               use_left;
    logic               use_right;
    logic               frame_end;
  } issue_t;

  // Window snapshot handed to the vote stage, taps in row-major order
  typedef struct packed {
    logic [WIN_TAPS-1:0][LABEL_W-1:0] lab;
    logic [WIN_TAPS-1:0]              tap_en;
    logic                             keep;
    logic                             frame_end;
  } vote_t;

  // Label = round_half_even(a / 180) mod 16. Two reciprocal products, one
  // for (a+90) and one for (a+89); they differ only on an exact tie.
  function automatic logic [LABEL_W-1:0] angle_label(input logic [ANGLE_W-1:0] a);
    logic [13:0] up;
    logic [13:0] lo;
    logic [27:0] pu;
    logic [27:0] pl;
    logic [5:0]  qu;
    logic [5:0]  ql;
    logic [5:0]  q;
    up = {1'b0, a} + HALF_STEP;
    lo = {1'b0, a} + (HALF_STEP - 14'd1);
    pu = {14'd0, up} * {14'd0, RECIP_MULT};
    pl = {14'd0, lo} * {14'd0, RECIP_MULT};
    qu = pu[RECIP_SHIFT+5:RECIP_SHIFT];
    ql = pl[RECIP_SHIFT+5:RECIP_SHIFT];
    // tie: round toward the even quotient
    q = ((qu != ql) && qu[0]) ? ql : qu;
    return q[LABEL_W-1:0];
  endfunction

endpackage

// File: rtl/core/gomv_front.sv
// Front end: column/row counters, frame sequencing and label computation.
// Depends on gomv_pkg; feeds gomv_window with one issue_t per stored item.
module gomv_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gomv_pkg::CFG_W-1:0]   frame_width_i,
  input  logic [gomv_pkg::CFG_W-1:0]   frame_height_i,
  input  logic                         take_i,
  input  logic [gomv_pkg::ANGLE_W-1:0] angle_i,
  input  logic [gomv_pkg::MAG_W-1:0]   mag_i,
  input  logic                         flush_i,
  output logic                         issue_valid_o,
  output gomv_pkg::issue_t             issue_o
);

  logic [gomv_pkg::ADDR_W-1:0]  col_q, col_d;
  logic [gomv_pkg::ROW_W-1:0]   row_q, row_d;
  logic [gomv_pkg::WIDTH_W-1:0] w_eff;
  logic [gomv_pkg::CFG_W-1:0]   h_eff;
  logic [gomv_pkg::ROW_W-1:0]   h_ext, h_p1;
  logic                         col_ge, past_end;
  logic [gomv_pkg::ADDR_W-1:0]  c1, x;
  logic [gomv_pkg::ROW_W-1:0]   r1, r;
  logic [gomv_pkg::WIDTH_W-1:0] x_next;
  logic                         drain, skip, deferred;

  // Effective geometry
  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = gomv_pkg::WIDTH_W'(1);
    end else if (int'(frame_width_i) > gomv_pkg::MAX_WIDTH) begin
      w_eff = gomv_pkg::WIDTH_W'(gomv_pkg::MAX_WIDTH);
    end else begin
      w_eff = gomv_pkg::WIDTH_W'(frame_width_i);
    end
    h_eff = (frame_height_i == '0) ? gomv_pkg::CFG_W'(1) : frame_height_i;
    h_ext = gomv_pkg::ROW_W'(h_eff);
    h_p1  = h_ext + gomv_pkg::ROW_W'(1);
  end

  // Position of this item, after catching up with a changed geometry
  always_comb begin
    col_ge   = {1'b0, col_q} >= w_eff;
    c1       = col_ge ? '0 : col_q;
    r1       = col_ge ? row_q + gomv_pkg::ROW_W'(1) : row_q;
    past_end = (r1 > h_p1) || ((r1 == h_p1) && (c1 != '0));
    x        = past_end ? '0 : c1;
    r        = past_end ? '0 : r1;
    drain    = r >= h_ext;
    skip     = !drain && flush_i;
    x_next   = {1'b0, x} + gomv_pkg::WIDTH_W'(1);
    deferred = (x == '0) && (r >= gomv_pkg::ROW_W'(2));
  end

  // Counter advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take_i) begin
      if (skip) begin
        col_d = x;
        row_d = r;
      end else if ((x == '0) && (r == h_p1)) begin
        col_d = '0;
        row_d = '0;
      end else if (x_next >= w_eff) begin
        col_d = '0;
        row_d = r + gomv_pkg::ROW_W'(1);
      end else begin
        col_d = x_next[gomv_pkg::ADDR_W-1:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Item for the window stage; drain items store label 0 and magnitude 0
  always_comb begin
    issue_valid_o     = take_i && !skip;
    issue_o.addr      = x;
    issue_o.lab       = drain ? '0 : gomv_pkg::angle_label(angle_i);
    issue_o.mag       = drain ? '0 : mag_i;
    issue_o.deferred  = deferred;
    issue_o.res       = deferred || ((x != '0) && (r != '0));
    issue_o.use_top   = deferred ? (r >= gomv_pkg::ROW_W'(3)) : (r >= gomv_pkg::ROW_W'(2));
    issue_o.use_bot   = deferred ? (r <= h_ext) : (r < h_ext);
    issue_o.use_left  = deferred ? (w_eff >= gomv_pkg::WIDTH_W'(2))
                                 : (x >= gomv_pkg::ADDR_W'(2));
    issue_o.use_right = !deferred;
    issue_o.frame_end = deferred && (r == h_p1);
  end

endmodule

// File: rtl/core/gomv_window.sv
// Window stage: line store memory (read-modify-write per item), forwarding,
// 3x3 label window and magnitude window. Depends on gomv_pkg.
module gomv_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gomv_pkg::MAG_W-1:0] threshold_i,
  input  logic                       issue_valid_i,
  input  gomv_pkg::issue_t           issue_i,
  output logic                       ready_o,
  output logic                       vote_valid_o,
  output gomv_pkg::vote_t            vote_o,
  input  logic                       vote_ready_i
);

  // Line store: {magnitude, label row b, label row a} per column
  logic [gomv_pkg::LINE_W-1:0] line_mem [gomv_pkg::MAX_WIDTH];
  logic [gomv_pkg::LINE_W-1:0] rdata_q;
  logic [gomv_pkg::LINE_W-1:0] rd, wr_data;

  logic                        fwd_valid_q;
  logic [gomv_pkg::ADDR_W-1:0] fwd_addr_q;
  logic [gomv_pkg::LINE_W-1:0] fwd_data_q;

  logic             p1_valid_q;
  gomv_pkg::issue_t p1_q;
  logic             p2_valid_q;
  gomv_pkg::vote_t  p2_q;
  gomv_pkg::vote_t  vote_d;

  logic [2:0][2:0][gomv_pkg::LABEL_W-1:0] win_q, win_n;
  logic [2:0][gomv_pkg::MAG_W-1:0]        mwin_q, mwin_n;
  logic [gomv_pkg::LABEL_W-1:0]           old_a, old_b;
  logic [gomv_pkg::MAG_W-1:0]             old_m, mag_sel;
  logic [2:0]                             row_en, col_en;

  logic p1_en, p1_adv, p2_en;

  // Stage handshake
  assign p2_en   = !p2_valid_q || vote_ready_i;
  assign p1_adv  = p1_valid_q && p2_en;
  assign p1_en   = !p1_valid_q || p2_en;
  assign ready_o = p1_en;

  // Memory: read at accept, write back when the item leaves this stage
  always_ff @(posedge clk_i) begin
    if (p1_en && issue_valid_i) begin
      rdata_q <= line_mem[issue_i.addr];
    end
    if (p1_adv) begin
      line_mem[p1_q.addr] <= wr_data;
    end
  end

  // Last write, for a read that passed the memory in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (p1_adv) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      fwd_addr_q <= p1_q.addr;
      fwd_data_q <= wr_data;
    end
  end

  // Window shift and write-back data
  always_comb begin
    rd = (fwd_valid_q && (fwd_addr_q == p1_q.addr)) ? fwd_data_q : rdata_q;
    old_a = rd[gomv_pkg::LABEL_W-1:0];
    old_b = rd[2*gomv_pkg::LABEL_W-1:gomv_pkg::LABEL_W];
    old_m = rd[gomv_pkg::LINE_W-1:2*gomv_pkg::LABEL_W];
    for (int i = 0; i < 3; i++) begin
      win_n[i][0] = win_q[i][1];
      win_n[i][1] = win_q[i][2];
    end
    win_n[0][2] = old_a;
    win_n[1][2] = old_b;
    win_n[2][2] = p1_q.lab;
    mwin_n[0] = mwin_q[1];
    mwin_n[1] = mwin_q[2];
    mwin_n[2] = old_m;
    wr_data = {p1_q.mag, p1_q.lab, old_b};
  end

  // Window snapshot: the deferred last-column centre uses the window
  // before this item's shift, every other centre the window after it
  always_comb begin
    row_en  = {p1_q.use_bot, 1'b1, p1_q.use_top};
    col_en  = {p1_q.use_right, 1'b1, p1_q.use_left};
    mag_sel = p1_q.deferred ? mwin_q[2] : mwin_n[1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (p1_q.deferred) begin
          vote_d.lab[3*i+j] = (j == 0) ? win_q[i][1] : ((j == 1) ? win_q[i][2] : '0);
        end else begin
          vote_d.lab[3*i+j] = win_n[i][j];
        end
        vote_d.tap_en[3*i+j] = row_en[i] && col_en[j];
      end
    end
    vote_d.keep      = mag_sel > threshold_i;
    vote_d.frame_end = p1_q.frame_end;
  end

  // Stage registers and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      win_q      <= '0;
      mwin_q     <= '0;
    end else begin
      if (p1_en) begin
        p1_valid_q <= issue_valid_i;
      end
      if (p2_en) begin
        p2_valid_q <= p1_adv && p1_q.res;
      end
      if (p1_adv) begin
        win_q  <= win_n;
        mwin_q <= mwin_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_en && issue_valid_i) begin
      p1_q <= issue_i;
    end
    if (p2_en) begin
      p2_q <= vote_d;
    end
  end

  assign vote_valid_o = p2_valid_q;
  assign vote_o       = p2_q;

endmodule

// File: rtl/core/gomv_vote.sv
// Vote stage: majority tally over the 3x3 window and the output register.
// Depends on gomv_pkg; takes vote_t items from gomv_window.
module gomv_vote (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vote_valid_i,
  input  gomv_pkg::vote_t                vote_i,
  output logic                           vote_ready_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gomv_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  logic                              out_valid_q;
  logic [gomv_pkg::NUM_LABELS-1:0]   bits_d, bits_q;
  logic                              last_q;
  logic                              out_en;

  // A label reaching the majority count is the only one that can, so the
  // row-major tie rule never matters for a nonzero result
  always_comb begin
    logic [gomv_pkg::CNT_W-1:0] cnt;
    bits_d = '0;
    for (int k = 0; k < gomv_pkg::WIN_TAPS; k++) begin
      cnt = '0;
      for (int j = 0; j < gomv_pkg::WIN_TAPS; j++) begin
        cnt = cnt + gomv_pkg::CNT_W'(vote_i.tap_en[j] && (vote_i.lab[j] == vote_i.lab[k]));
      end
      if (vote_i.tap_en[k] && (int'(cnt) >= gomv_pkg::VOTE_MIN)) begin
        bits_d[vote_i.lab[k]] = 1'b1;
      end
    end
    if (!vote_i.keep) begin
      bits_d = '0;
    end
  end

  // Output register
  assign out_en       = !out_valid_q || m_axis_tready;
  assign vote_ready_o = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= vote_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && vote_valid_i) begin
      bits_q <= bits_d;
      last_q <= vote_i.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = gomv_pkg::M_TDATA_W'(bits_q);
  assign m_axis_tlast  = last_q;

endmodule

// File: rtl/core/gradient_orientation_majority_vote.sv
// Gradient orientation majority vote, top level: configuration registers,
// stream ports and the front / window / vote pipeline. Depends on gomv_pkg,
// gomv_front, gomv_window and gomv_vote.
//
// Pixels enter in raster order, one item per clock when both sides keep up.
// Each pixel gets a 4-bit orientation label that goes into a single line
// store (one 23-bit word per column: two label rows and one magnitude row),
// read when the item is accepted and written back as the item moves on; a
// forwarding register covers back-to-back items at the same column, so the
// store's one read and one write per cycle set the one-item-per-clock rate.
// The result for a centre pixel is the 16-bit one-hot label that holds at
// least 5 votes of its in-image 3x3 window (zero otherwise, or when the
// centre magnitude does not exceed the threshold). It belongs to the item
// W+1 positions later in the stream, so a frame takes H*W pixel items plus
// W+1 drain items (tuser ignored); tlast marks the frame's last result. Flush
// items inside the image are taken and dropped. The line store has no reset
// or clearing pass; no result uses an entry the frame has not written.
// Results pass the window stage registers and the vote output register.
// Registers (write only while the block is idle): 0x0 magnitude threshold,
// 0x4 frame width, 0x8 frame height.
module gradient_orientation_majority_vote (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gomv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gomv_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gomv_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // Pixel stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gomv_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [12:0] angle_sixteenths,
                                                         // [27:13] magnitude, [31:28] zero
  input  logic                            s_axis_tuser,  // [0] flush
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gomv_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [15:0] orientation_bits
  output logic                            m_axis_tlast   // frame_end
);

  logic [gomv_pkg::MAG_W-1:0] threshold_q;
  logic [gomv_pkg::CFG_W-1:0] width_q;
  logic [gomv_pkg::CFG_W-1:0] height_q;
  gomv_pkg::reg_idx_e         reg_idx;
  logic                       take;
  logic                       issue_valid;
  gomv_pkg::issue_t           issue;
  logic                       vote_valid;
  logic                       vote_ready;
  gomv_pkg::vote_t            vote;

  // Register decode
  assign reg_idx = gomv_pkg::reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= gomv_pkg::THRESHOLD_RESET;
      width_q     <= gomv_pkg::WIDTH_RESET;
      height_q    <= gomv_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        gomv_pkg::REG_THRESHOLD: threshold_q <= pwdata[gomv_pkg::MAG_W-1:0];
        gomv_pkg::REG_WIDTH:     width_q     <= pwdata[gomv_pkg::CFG_W-1:0];
        gomv_pkg::REG_HEIGHT:    height_q    <= pwdata[gomv_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      gomv_pkg::REG_THRESHOLD: prdata = gomv_pkg::APB_DATA_W'(threshold_q);
      gomv_pkg::REG_WIDTH:     prdata = gomv_pkg::APB_DATA_W'(width_q);
      gomv_pkg::REG_HEIGHT:    prdata = gomv_pkg::APB_DATA_W'(height_q);
      default:                 prdata = '0;
    endcase
  end

  assign take = s_axis_tvalid && s_axis_tready;

  gomv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .take_i         (take),
    .angle_i        (s_axis_tdata[gomv_pkg::ANGLE_W-1:0]),
    .mag_i          (s_axis_tdata[gomv_pkg::ANGLE_W+gomv_pkg::MAG_W-1:gomv_pkg::ANGLE_W]),
    .flush_i        (s_axis_tuser),
    .issue_valid_o  (issue_valid),
    .issue_o        (issue)
  );

  gomv_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .threshold_i   (threshold_q),
    .issue_valid_i (issue_valid),
    .issue_i       (issue),
    .ready_o       (s_axis_tready),
    .vote_valid_o  (vote_valid),
    .vote_o        (vote),
    .vote_ready_i  (vote_ready)
  );

  gomv_vote u_vote (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vote_valid_i  (vote_valid),
    .vote_i        (vote),
    .vote_ready_o  (vote_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: tb/tb_top.sv
// Testbench for gradient_orientation_majority_vote: raster frames of gradient
// pixels go in over the stream port and each 3x3 vote result is checked against
// an in-bench model. Depends on gomv_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb_top;
  import gomv_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 8;
  localparam int RAND_ITEMS   = 450;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [MAG_W-1:0]   mag;
    logic               flush;
  } pixel_t;

  typedef struct packed {
    logic [M_TDATA_W-1:0] bits;
    logic                 frame_end;
  } vote_res_t;

  typedef logic [2:0][2:0][LABEL_W-1:0] window_t;

  // Clock, reset and every block input start at known values
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_tvalid      = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_tdata       = '0;
  logic                   s_tuser       = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_ready       = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  gradient_orientation_majority_vote dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),   // [12:0] angle_sixteenths, [27:13] magnitude, [31:28] zero
    .s_axis_tuser  (s_tuser),   // [0] flush
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // [15:0] orientation_bits
    .m_axis_tlast  (m_axis_tlast)   // frame_end
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  pixel_t      pixel_feed[$];
  vote_res_t   pending_votes[$];
  int unsigned cycles     = 0;
  int unsigned fail_count = 0;
  int unsigned queued     = 0;
  logic        in_fire    = 1'b0;
  bit          want_hold  = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;

  // Model copy of the registers and the block state
  logic [MAG_W-1:0]   cfg_thr = THRESHOLD_RESET;
  logic [CFG_W-1:0]   cfg_w   = WIDTH_RESET;
  logic [CFG_W-1:0]   cfg_h   = HEIGHT_RESET;
  logic [LABEL_W-1:0] line_far  [MAX_WIDTH] = '{default: '0};
  logic [LABEL_W-1:0] line_near [MAX_WIDTH] = '{default: '0};
  logic [MAG_W-1:0]   mag_row   [MAX_WIDTH] = '{default: '0};
  window_t            win_lab = '0;
  logic [2:0][MAG_W-1:0] win_mag = '0;
  int                 col_cnt = 0;
  int                 row_cnt = 0;

  // Cycle counter and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Periodic stretch in which neither side idles at random
  function automatic bit steady_stretch();
    return (cycles % 3000) < 700;
  endfunction

  function automatic int eff_width();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_WIDTH) return MAX_WIDTH;
    return cfg_w;
  endfunction

  function automatic int eff_height();
    return (cfg_h == 0) ? 1 : cfg_h;
  endfunction

  // angle / 180, rounded half to even, kept to 4 bits
  function automatic logic [LABEL_W-1:0] orient_label(input logic [ANGLE_W-1:0] a);
    int unsigned q;
    int unsigned rem;
    q   = a / 180;
    rem = a % 180;
    if (rem > 90 || (rem == 90 && (q % 2) == 1)) q++;
    return q[LABEL_W-1:0];
  endfunction

  // Row-major tally; a label wins only on a strictly greater count
  function automatic logic [M_TDATA_W-1:0] vote_bits(input window_t t, input bit top,
                                                     input bit bot, input bit left,
                                                     input bit right, input logic [MAG_W-1:0] m);
    int cnt [NUM_LABELS];
    int best;
    int maxv;
    int i;
    int j;
    best = 0;
    maxv = 0;
    for (i = 0; i < NUM_LABELS; i++) cnt[i] = 0;
    if (m <= cfg_thr) return '0;
    for (i = 0; i < 3; i++) begin
      if ((i == 0 && !top) || (i == 2 && !bot)) continue;
      for (j = 0; j < 3; j++) begin
        if ((j == 0 && !left) || (j == 2 && !right)) continue;
        cnt[t[i][j]]++;
        if (cnt[t[i][j]] > maxv) begin
          maxv = cnt[t[i][j]];
          best = t[i][j];
        end
      end
    end
    return (maxv >= VOTE_MIN) ? (16'd1 << best) : '0;
  endfunction

  // Advance the model by one accepted item; queue the result it causes
  task automatic vote_model_step(input logic [ANGLE_W-1:0] a, input logic [MAG_W-1:0] m,
                                 input logic fl);
    int w;
    int h;
    int x;
    int r;
    int i;
    bit drain;
    bit have;
    logic [LABEL_W-1:0] lab;
    logic [MAG_W-1:0]   mag;
    logic [LABEL_W-1:0] old_far;
    logic [LABEL_W-1:0] old_near;
    logic [MAG_W-1:0]   old_mag;
    window_t   t;
    vote_res_t res;
    w = eff_width();
    h = eff_height();
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt > h + 1 || (row_cnt == h + 1 && col_cnt != 0)) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    x = col_cnt;
    r = row_cnt;
    drain = (r >= h);
    // flush inside the image is dropped
    if (!drain && fl) return;
    lab  = '0;
    mag  = '0;
    have = 1'b0;
    res  = '0;
    if (!drain) begin
      lab = orient_label(a);
      mag = m;
    end
    // deferred result for the last column of the row two up
    if (x == 0 && r >= 2) begin
      t = '0;
      for (i = 0; i < 3; i++) begin
        t[i][0] = win_lab[i][1];
        t[i][1] = win_lab[i][2];
      end
      res.bits      = vote_bits(t, r >= 3, (r - 1) < h, w >= 2, 1'b0, win_mag[2]);
      res.frame_end = (r == h + 1);
      have = 1'b1;
    end
    old_far  = line_far[x];
    old_near = line_near[x];
    old_mag  = mag_row[x];
    for (i = 0; i < 3; i++) begin
      win_lab[i][0] = win_lab[i][1];
      win_lab[i][1] = win_lab[i][2];
    end
    win_lab[0][2] = old_far;
    win_lab[1][2] = old_near;
    win_lab[2][2] = lab;
    win_mag[0]    = win_mag[1];
    win_mag[1]    = win_mag[2];
    win_mag[2]    = old_mag;
    line_far[x]   = old_near;
    line_near[x]  = lab;
    mag_row[x]    = mag;
    // result for the centre one row up, one column left
    if (x >= 1 && r >= 1) begin
      res.bits      = vote_bits(win_lab, r >= 2, r < h, x >= 2, 1'b1, win_mag[1]);
      res.frame_end = 1'b0;
      have = 1'b1;
    end
    if (have) pending_votes = {pending_votes, res};
    if (x == 0 && r == h + 1) begin
      row_cnt = 0;
      col_cnt = 0;
    end else begin
      col_cnt = x + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = r + 1;
      end
    end
  endtask

  // Input side: predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready)
      vote_model_step(s_tdata[ANGLE_W-1:0], s_tdata[ANGLE_W+MAG_W-1:ANGLE_W], s_tuser);
    in_fire <= rst_ni && s_tvalid && s_axis_tready;
  end

  // Pixel driver, fed from pixel_feed
  always @(negedge clk_i) begin : feed_drive
    pixel_t nxt;
    if (rst_ni && (in_fire || !s_tvalid)) begin
      if (pixel_feed.size() != 0 && (steady_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pixel_feed.pop_front();
        s_tdata  <= {4'd0, nxt.mag, nxt.angle};
        s_tuser  <= nxt.flush;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= 1'b1;
      m_ready <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= steady_stretch() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    vote_res_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_votes.size() == 0) begin
        $error("result with nothing pending: orientation_bits %h frame_end %b",
               m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_votes.pop_front();
        if (m_axis_tdata !== want.bits) begin
          $error("orientation_bits expected %h actual %h", want.bits, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $error("frame_end expected %b actual %b", want.frame_end, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input bit wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input reg_idx_e idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $error("register %s expected %h actual %h", idx.name(), want, rd);
      fail_count++;
    end
  endtask

  // Write a register, mirror it in the model, read it back
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] kept;
    kept = (idx == REG_THRESHOLD) ? (val & ((32'd1 << MAG_W) - 1))
                                  : (val & ((32'd1 << CFG_W) - 1));
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_THRESHOLD: cfg_thr = kept[MAG_W-1:0];
      REG_WIDTH:     cfg_w   = kept[CFG_W-1:0];
      REG_HEIGHT:    cfg_h   = kept[CFG_W-1:0];
      default: ;
    endcase
    reg_check(idx, kept);
  endtask

  task automatic set_config(input int thr, input int w, input int h);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  task automatic push_item(input int a, input int m, input bit fl);
    pixel_t p;
    p.angle = a[ANGLE_W-1:0];
    p.mag   = m[MAG_W-1:0];
    p.flush = fl;
    pixel_feed = {pixel_feed, p};
    queued++;
  endtask

  // Wait until everything is accepted and answered, then let the pipe settle
  task automatic wait_idle();
    while (pixel_feed.size() != 0 || s_tvalid) @(posedge clk_i);
    while (pending_votes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Angles cluster around a frame base so that votes often reach a majority
  function automatic int rand_angle(input int base);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return (base + 5760 + $urandom_range(80) - 40) % 5760;
      6, 7:             return $urandom_range(5759);
      8:                return $urandom_range(8191);
      default:          return 180 * $urandom_range(44) + 90;  // exact tie
    endcase
  endfunction

  function automatic int rand_mag();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(25600);
      5:             return cfg_thr;
      6:             return cfg_thr + 1;
      7:             return 0;
      8:             return $urandom_range(1) ? 25600 : 32767;
      default:       return $urandom_range(32767);
    endcase
  endfunction

  // One full frame: pixels with stray flushes, then the drain items
  task automatic add_frame();
    int w;
    int h;
    int i;
    int base;
    w = eff_width();
    h = eff_height();
    base = $urandom_range(5759);
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 4) push_item(rand_angle(base), rand_mag(), 1'b1);
      push_item(rand_angle(base), rand_mag(), 1'b0);
    end
    // drain; some look like ordinary pixels
    for (i = 0; i <= w; i++)
      push_item($urandom_range(8191), $urandom_range(32767), $urandom_range(99) < 70);
    if ($urandom_range(9) == 0) push_item($urandom_range(8191), $urandom_range(32767), 1'b1);
  endtask

  initial begin : stimulus
    int n0;
    int w;
    int h;
    int thr;
    int k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    reg_check(REG_THRESHOLD, 32'(THRESHOLD_RESET));
    reg_check(REG_WIDTH, 32'(WIDTH_RESET));
    reg_check(REG_HEIGHT, 32'(HEIGHT_RESET));

    // Directed 3x3 frame: ties, wrap-around, full-field values, stray flush
    set_config(0, 3, 3);
    push_item(0, 25600, 1'b0);
    push_item(89, 1, 1'b0);
    push_item(90, 0, 1'b0);
    push_item(5759, 32767, 1'b1);
    push_item(270, 32767, 1'b0);
    push_item(5759, 100, 1'b0);
    push_item(91, 5, 1'b0);
    push_item(8191, 1, 1'b0);
    push_item(0, 2, 1'b0);
    push_item(179, 3, 1'b0);
    push_item(0, 0, 1'b1);
    push_item(5759, 25600, 1'b0);
    push_item(8191, 32767, 1'b1);
    push_item(0, 0, 1'b0);
    wait_idle();

    // Zero width and height act as one; magnitude just above the threshold
    set_config(25599, 0, 0);
    push_item(4000, 25600, 1'b0);
    push_item(0, 0, 1'b1);
    push_item(8191, 32767, 1'b0);
    wait_idle();

    // Random phases, mostly small frames
    n0 = queued;
    while (queued - n0 < RAND_ITEMS) begin
      k = $urandom_range(19);
      if (k == 0) w = 0;
      else if (k == 1) w = 1;
      else if (k == 2) w = $urandom_range(13, 24);
      else w = $urandom_range(2, 12);
      k = $urandom_range(19);
      if (k == 0) h = 0;
      else if (k == 1) h = 1;
      else if (k == 2) h = $urandom_range(9, 12);
      else h = $urandom_range(2, 8);
      case ($urandom_range(9))
        0:       thr = 0;
        1:       thr = 25600;
        2:       thr = 32767;
        3, 4:    thr = $urandom_range(255);
        default: thr = $urandom_range(25600);
      endcase
      set_config(thr, w, h);
      repeat ($urandom_range(1, 2)) add_frame();
      wait_idle();
    end

    // Wide frame, with the receiver holding off while the sender fills the block
    want_hold = 1'b1;
    set_config($urandom_range(7680), 96, 2);
    add_frame();
    wait_idle();

    // Width above the line store size reads back as written; then a tall frame
    set_config($urandom_range(7680), 2047, 1);
    set_config($urandom_range(7680), 1, 256);
    add_frame();
    wait_idle();

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
